/* sv/bankers_safety_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Banker's allocator assertion macros
// Concurrent checks on the rising edge of clock, muted while reset is high.
// ----------------------------------------------------------------------------
`ifndef BANKERS_SAFETY_ALLOCATOR_MACROS_SVH
`define BANKERS_SAFETY_ALLOCATOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define BSA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define BSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// Banker's allocator package
// Shared types, register indexes, command and status codes.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int BYTE_W        = 8;
   localparam int WORK_W        = 11;
   localparam int CSR_W         = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int CFG_CUSTOMERS = 5;
   localparam int FIELD_COUNT   = 4;
   localparam int CUST_W        = 3;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [WORK_W-1:0] work_type;
   typedef logic [CSR_W-1:0]  csr_word_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOTAL  = 3'd0,
      REG_CLAIM0 = 3'd1,
      REG_CLAIM1 = 3'd2,
      REG_CLAIM2 = 3'd3,
      REG_CLAIM3 = 3'd4,
      REG_CLAIM4 = 3'd5
   } reg_index_type;

   localparam int REG_COUNT = 6;

   typedef enum logic {
      CMD_REQUEST = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      RSP_GRANTED     = 3'd0,
      RSP_UNSAFE      = 3'd1,
      RSP_UNAVAILABLE = 3'd2,
      RSP_OVER_CLAIM  = 3'd3,
      RSP_RELEASED    = 3'd4,
      RSP_REFUSED     = 3'd5
   } status_type;

   function automatic byte_type sat_sub(input byte_type a, input byte_type b);
      sat_sub = (a > b) ? byte_type'(a - b) : '0;
   endfunction

endpackage

/* sv/bankers_safety_allocator.sv */
// ----------------------------------------------------------------------------
// Banker's safety allocator
// Grants, denies and releases units; a grant is kept only if a safe order
// exists. One sequencer drives a shared lane compare/add unit.
// ----------------------------------------------------------------------------
// channel   ports                         handshake
// request   req_command/customer/amount   start, taken when busy is low
// response  rsp_status, rsp_avail_0..3    rsp_valid, one cycle, no back-pressure
// config    csr_index, csr_wdata          csr_write_en, taken at once
//
// Bad customer index: straight to the response. Request: need, then free units;
// release: holdings. Both update holdings and granted totals; a grant's safety
// walk makes N = NUM_CUSTOMERS passes of one customer per cycle; undone if unsafe.
// busy is high from the cycle after start until the response is raised.
// Reset clears holdings, totals, registers and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
`include "bankers_safety_allocator_macros.svh"

module bankers_safety_allocator import bsa_pkg::*; #(
   parameter int NUM_CUSTOMERS = 5,
   parameter int NUM_RESOURCES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_command,
   input  logic [CUST_W-1:0]    req_customer,
   input  logic [BYTE_W-1:0]    req_amount_0,
   input  logic [BYTE_W-1:0]    req_amount_1,
   input  logic [BYTE_W-1:0]    req_amount_2,
   input  logic [BYTE_W-1:0]    req_amount_3,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [BYTE_W-1:0]    rsp_avail_0,
   output logic [BYTE_W-1:0]    rsp_avail_1,
   output logic [BYTE_W-1:0]    rsp_avail_2,
   output logic [BYTE_W-1:0]    rsp_avail_3,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(NUM_CUSTOMERS);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_OVER   = 11'b000_0000_0010,
      ST_AVAIL  = 11'b000_0000_0100,
      ST_REL    = 11'b000_0000_1000,
      ST_UPD_H  = 11'b000_0001_0000,
      ST_UPD_G  = 11'b000_0010_0000,
      ST_INIT   = 11'b000_0100_0000,
      ST_SAFE   = 11'b000_1000_0000,
      ST_UNDO_H = 11'b001_0000_0000,
      ST_UNDO_G = 11'b010_0000_0000,
      ST_DONE   = 11'b100_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   command_type        cmd_ff, cmd_in;
   logic [CW-1:0]      cust_ff, cust_in;
   byte_type           amt_ff [NUM_RESOURCES];
   byte_type           amt_in [NUM_RESOURCES];
   byte_type           held_ff [NUM_CUSTOMERS][NUM_RESOURCES];
   byte_type           held_in [NUM_CUSTOMERS][NUM_RESOURCES];
   byte_type           granted_ff [NUM_RESOURCES];
   byte_type           granted_in [NUM_RESOURCES];
   work_type           work_ff [NUM_RESOURCES];
   work_type           work_in [NUM_RESOURCES];
   logic [NUM_CUSTOMERS-1:0] done_ff, done_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [CW-1:0]      pass_ff, pass_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   byte_type           rsp_avail_ff [FIELD_COUNT];
   byte_type           rsp_avail_in [FIELD_COUNT];

   byte_type           req_amt [FIELD_COUNT];
   logic [CW-1:0]      sel;
   byte_type           held_sel  [NUM_RESOURCES];
   byte_type           total_vec [NUM_RESOURCES];
   byte_type           claim_vec [NUM_RESOURCES];
   byte_type           need_sel  [NUM_RESOURCES];
   byte_type           avail_vec [NUM_RESOURCES];
   work_type           op_a [NUM_RESOURCES];
   work_type           op_b [NUM_RESOURCES];
   work_type           op_c [NUM_RESOURCES];
   work_type           sum_vec [NUM_RESOURCES];
   logic               all_le;
   logic               neg_amt;

   assign req_amt[0] = req_amount_0;
   assign req_amt[1] = req_amount_1;
   assign req_amt[2] = req_amount_2;
   assign req_amt[3] = req_amount_3;

   bsa_regfile #(
      .NUM_CUSTOMERS (NUM_CUSTOMERS),
      .NUM_RESOURCES (NUM_RESOURCES)
   ) u_regfile (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .claim_sel    (sel),
      .total_vec    (total_vec),
      .claim_vec    (claim_vec)
   );

   bsa_vec_unit #(
      .NUM_RESOURCES (NUM_RESOURCES)
   ) u_vec_unit (
      .a_vec   (op_a),
      .b_vec   (op_b),
      .c_vec   (op_c),
      .all_le  (all_le),
      .sum_vec (sum_vec)
   );

   assign sel      = (state_ff == ST_SAFE) ? k_ff : cust_ff;
   assign held_sel = held_ff[sel];
   assign neg_amt  = (state_ff == ST_UNDO_H) || (state_ff == ST_UNDO_G) ||
                     (cmd_ff == CMD_RELEASE);

   always_comb begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         need_sel[r]  = sat_sub(claim_vec[r], held_sel[r]);
         avail_vec[r] = sat_sub(total_vec[r], granted_ff[r]);
      end
   end

   // operand routing for the shared unit
   always_comb begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         op_a[r] = WORK_W'(amt_ff[r]);
         op_b[r] = work_ff[r];
         op_c[r] = neg_amt ? work_type'(WORK_W'(0) - WORK_W'(amt_ff[r]))
                           : WORK_W'(amt_ff[r]);
         case (state_ff)
            ST_OVER: begin
               op_b[r] = WORK_W'(need_sel[r]);
            end
            ST_AVAIL: begin
               op_b[r] = WORK_W'(avail_vec[r]);
            end
            ST_REL, ST_UPD_H, ST_UNDO_H: begin
               op_b[r] = WORK_W'(held_sel[r]);
            end
            ST_UPD_G, ST_UNDO_G: begin
               op_b[r] = WORK_W'(granted_ff[r]);
            end
            ST_SAFE: begin
               op_a[r] = WORK_W'(need_sel[r]);
               op_c[r] = WORK_W'(held_sel[r]);
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cust_in      = cust_ff;
      amt_in       = amt_ff;
      held_in      = held_ff;
      granted_in   = granted_ff;
      work_in      = work_ff;
      done_in      = done_ff;
      k_in         = k_ff;
      pass_in      = pass_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_avail_in = rsp_avail_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in  = command_type'(req_command);
               cust_in = req_customer[CW-1:0];
               for (int r = 0; r < NUM_RESOURCES; r++) begin
                  amt_in[r] = (r < FIELD_COUNT) ? req_amt[r % FIELD_COUNT] : '0;
               end
               if (req_customer >= CUST_W'(NUM_CUSTOMERS)) begin
                  status_in = (req_command == CMD_RELEASE) ? RSP_REFUSED : RSP_OVER_CLAIM;
                  state_in  = ST_DONE;
               end else if (req_command == CMD_RELEASE) begin
                  state_in = ST_REL;
               end else begin
                  state_in = ST_OVER;
               end
            end
         end
         ST_OVER: begin
            if (all_le) begin
               state_in = ST_AVAIL;
            end else begin
               status_in = RSP_OVER_CLAIM;
               state_in  = ST_DONE;
            end
         end
         ST_AVAIL: begin
            if (all_le) begin
               state_in = ST_UPD_H;
            end else begin
               status_in = RSP_UNAVAILABLE;
               state_in  = ST_DONE;
            end
         end
         ST_REL: begin
            if (all_le) begin
               state_in = ST_UPD_H;
            end else begin
               status_in = RSP_REFUSED;
               state_in  = ST_DONE;
            end
         end
         ST_UPD_H, ST_UNDO_H: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               held_in[cust_ff][r] = sum_vec[r][BYTE_W-1:0];
            end
            state_in = (state_ff == ST_UPD_H) ? ST_UPD_G : ST_UNDO_G;
         end
         ST_UPD_G: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               granted_in[r] = sum_vec[r][BYTE_W-1:0];
            end
            if (cmd_ff == CMD_RELEASE) begin
               status_in = RSP_RELEASED;
               state_in  = ST_DONE;
            end else begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               work_in[r] = WORK_W'(avail_vec[r]);
            end
            done_in  = '0;
            k_in     = '0;
            pass_in  = '0;
            state_in = ST_SAFE;
         end
         ST_SAFE: begin
            if (!done_ff[k_ff] && all_le) begin
               done_in[k_ff] = 1'b1;
               work_in       = sum_vec;
            end
            if (k_ff == CW'(NUM_CUSTOMERS - 1)) begin
               k_in = '0;
               if (pass_ff == CW'(NUM_CUSTOMERS - 1)) begin
                  if (&done_in) begin
                     status_in = RSP_GRANTED;
                     state_in  = ST_DONE;
                  end else begin
                     status_in = RSP_UNSAFE;
                     state_in  = ST_UNDO_H;
                  end
               end else begin
                  pass_in = pass_ff + CW'(1);
               end
            end else begin
               k_in = k_ff + CW'(1);
            end
         end
         ST_UNDO_G: begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               granted_in[r] = sum_vec[r][BYTE_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            for (int f = 0; f < FIELD_COUNT; f++) begin
               rsp_avail_in[f] = (f < NUM_RESOURCES) ? avail_vec[f % NUM_RESOURCES] : '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CUSTOMERS; c++) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               held_ff[c][r] <= '0;
            end
         end
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            granted_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_ff      <= held_in;
         granted_ff   <= granted_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cust_ff      <= cust_in;
      amt_ff       <= amt_in;
      work_ff      <= work_in;
      done_ff      <= done_in;
      k_ff         <= k_in;
      pass_ff      <= pass_in;
      status_ff    <= status_in;
      rsp_avail_ff <= rsp_avail_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = status_ff;
   assign rsp_avail_0 = rsp_avail_ff[0];
   assign rsp_avail_1 = rsp_avail_ff[1];
   assign rsp_avail_2 = rsp_avail_ff[2];
   assign rsp_avail_3 = rsp_avail_ff[3];

   `BSA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
   `BSA_ASSERT_SAME(a_rsp_from_done, rsp_valid, $past(state_ff == ST_DONE), "stray response")
   `BSA_ASSERT_SAME(a_grant_safe, rsp_valid && (rsp_status == RSP_GRANTED), &done_ff, "grant unsafe")
   `BSA_ASSERT_NEXT(a_done_grows, state_ff == ST_SAFE, ($past(done_ff) & ~done_ff) == '0, "done lost")

endmodule

/* sv/bsa_regfile.sv */
// ----------------------------------------------------------------------------
// Banker's allocator register file
// Holds total units and claims; presents the total vector and one claim row.
// ----------------------------------------------------------------------------
module bsa_regfile import bsa_pkg::*; #(
   parameter int NUM_CUSTOMERS = 5,
   parameter int NUM_RESOURCES = 4,
   localparam int CW           = $clog2(NUM_CUSTOMERS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  csr_word_type         csr_wdata,
   input  logic [CW-1:0]        claim_sel,
   output byte_type             total_vec [NUM_RESOURCES],
   output byte_type             claim_vec [NUM_RESOURCES]
);

   csr_word_type regs_ff [REG_COUNT];
   csr_word_type regs_in [REG_COUNT];
   csr_word_type claim_word;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_en && (csr_index < CSR_IDX_W'(REG_COUNT))) begin
         regs_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      claim_word = '0;
      if (CSR_IDX_W'(claim_sel) < CSR_IDX_W'(CFG_CUSTOMERS)) begin
         claim_word = regs_ff[CSR_IDX_W'(REG_CLAIM0) + CSR_IDX_W'(claim_sel)];
      end
   end

   for (genvar r = 0; r < NUM_RESOURCES; r++) begin : g_field
      if (r < FIELD_COUNT) begin : g_live
         assign total_vec[r] = regs_ff[REG_TOTAL][BYTE_W*r +: BYTE_W];
         assign claim_vec[r] = claim_word[BYTE_W*r +: BYTE_W];
      end else begin : g_zero
         assign total_vec[r] = '0;
         assign claim_vec[r] = '0;
      end
   end

endmodule

/* sv/bsa_vec_unit.sv */
// ----------------------------------------------------------------------------
// Banker's allocator vector unit
// Shared lane compare (a <= b in every lane) and lane add (b + c).
// ----------------------------------------------------------------------------
module bsa_vec_unit import bsa_pkg::*; #(
   parameter int NUM_RESOURCES = 4
) (
   input  work_type a_vec   [NUM_RESOURCES],
   input  work_type b_vec   [NUM_RESOURCES],
   input  work_type c_vec   [NUM_RESOURCES],
   output logic     all_le,
   output work_type sum_vec [NUM_RESOURCES]
);

   logic [NUM_RESOURCES-1:0] lane_le;

   always_comb begin
      for (int r = 0; r < NUM_RESOURCES; r++) begin
         lane_le[r] = (a_vec[r] <= b_vec[r]);
         sum_vec[r] = b_vec[r] + c_vec[r];
      end
   end

   assign all_le = &lane_le;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Banker's safety allocator testbench
// Drives request and release transactions through the start/busy port, holds
// its own copy of the holdings, totals and claim registers, and predicts the
// status and available vector of every response. A short scripted sequence
// covers reset state, bad customer indexes, over claim, shortage, unsafe
// denial and registers lowered below what is held; random phases follow, each
// with its own register setting and one of three sender gap rates.
// ----------------------------------------------------------------------------
module testbench;
   import bsa_pkg::*;

   typedef struct {
      command_type                 cmd;
      logic [CUST_W-1:0]           customer;
      byte_type [FIELD_COUNT-1:0]  amount;
   } alloc_req_type;

   typedef struct {
      status_type                  status;
      byte_type [FIELD_COUNT-1:0]  avail;
   } alloc_rsp_type;

   typedef struct {
      bit            is_write;
      reg_index_type reg_sel;
      csr_word_type  wdata;
      alloc_req_type item;
      bit            typed;
      status_type    want_status;
      byte_type      want_avail;
   } script_row_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_command;
   logic [CUST_W-1:0]    req_customer;
   logic [BYTE_W-1:0]    req_amount_0;
   logic [BYTE_W-1:0]    req_amount_1;
   logic [BYTE_W-1:0]    req_amount_2;
   logic [BYTE_W-1:0]    req_amount_3;
   logic                 rsp_valid;
   logic [2:0]           rsp_status;
   logic [BYTE_W-1:0]    rsp_avail_0;
   logic [BYTE_W-1:0]    rsp_avail_1;
   logic [BYTE_W-1:0]    rsp_avail_2;
   logic [BYTE_W-1:0]    rsp_avail_3;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   csr_word_type reg_words [REG_COUNT];
   byte_type     held [CFG_CUSTOMERS][FIELD_COUNT];
   byte_type     held_total [FIELD_COUNT];

   alloc_rsp_type   pending_outcomes [$];
   script_row_type  script [$];
   int           failures = 0;
   int           issued = 0;
   int           received = 0;
   int           settings = 0;
   int           outcome_count [6];

   bankers_safety_allocator dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_command  (req_command),
      .req_customer (req_customer),
      .req_amount_0 (req_amount_0),
      .req_amount_1 (req_amount_1),
      .req_amount_2 (req_amount_2),
      .req_amount_3 (req_amount_3),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_avail_0  (rsp_avail_0),
      .rsp_avail_1  (rsp_avail_1),
      .rsp_avail_2  (rsp_avail_2),
      .rsp_avail_3  (rsp_avail_3),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("bankers_safety_allocator verification failed");
      $finish;
   end

   function automatic int unsigned avail_units(int r);
      int unsigned t;
      int unsigned g;
      t = reg_words[REG_TOTAL][8*r +: 8];
      g = held_total[r];
      return (t > g) ? t - g : 0;
   endfunction

   function automatic int unsigned need_units(int c, int r);
      int unsigned m;
      int unsigned h;
      m = reg_words[int'(REG_CLAIM0) + c][8*r +: 8];
      h = held[c][r];
      return (m > h) ? m - h : 0;
   endfunction

   function automatic bit safe_order_exists();
      int unsigned work [FIELD_COUNT];
      bit          finished [CFG_CUSTOMERS];
      bit          fits;
      for (int r = 0; r < FIELD_COUNT; r++) work[r] = avail_units(r);
      for (int c = 0; c < CFG_CUSTOMERS; c++) finished[c] = 1'b0;
      for (int pass = 0; pass < CFG_CUSTOMERS; pass++) begin
         for (int c = 0; c < CFG_CUSTOMERS; c++) begin
            if (!finished[c]) begin
               fits = 1'b1;
               for (int r = 0; r < FIELD_COUNT; r++)
                  if (need_units(c, r) > work[r]) fits = 1'b0;
               if (fits) begin
                  finished[c] = 1'b1;
                  for (int r = 0; r < FIELD_COUNT; r++) work[r] += held[c][r];
               end
            end
         end
      end
      for (int c = 0; c < CFG_CUSTOMERS; c++)
         if (!finished[c]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic alloc_rsp_type allocate_outcome(alloc_req_type q);
      alloc_rsp_type res;
      int         c;
      bit         over;
      bit         short_of;
      c = q.customer;
      over = 1'b0;
      short_of = 1'b0;
      if (q.cmd == CMD_REQUEST) begin
         if (c >= CFG_CUSTOMERS) begin
            res.status = RSP_OVER_CLAIM;
         end else begin
            for (int r = 0; r < FIELD_COUNT; r++) begin
               if (q.amount[r] > need_units(c, r)) over = 1'b1;
               if (q.amount[r] > avail_units(r)) short_of = 1'b1;
            end
            if (over) begin
               res.status = RSP_OVER_CLAIM;
            end else if (short_of) begin
               res.status = RSP_UNAVAILABLE;
            end else begin
               for (int r = 0; r < FIELD_COUNT; r++) begin
                  held[c][r] = byte_type'(held[c][r] + q.amount[r]);
                  held_total[r] = byte_type'(held_total[r] + q.amount[r]);
               end
               if (safe_order_exists()) begin
                  res.status = RSP_GRANTED;
               end else begin
                  for (int r = 0; r < FIELD_COUNT; r++) begin
                     held[c][r] = byte_type'(held[c][r] - q.amount[r]);
                     held_total[r] = byte_type'(held_total[r] - q.amount[r]);
                  end
                  res.status = RSP_UNSAFE;
               end
            end
         end
      end else begin
         if (c >= CFG_CUSTOMERS) begin
            res.status = RSP_REFUSED;
         end else begin
            for (int r = 0; r < FIELD_COUNT; r++)
               if (q.amount[r] > held[c][r]) over = 1'b1;
            if (over) begin
               res.status = RSP_REFUSED;
            end else begin
               for (int r = 0; r < FIELD_COUNT; r++) begin
                  held[c][r] = byte_type'(held[c][r] - q.amount[r]);
                  held_total[r] = byte_type'(held_total[r] - q.amount[r]);
               end
               res.status = RSP_RELEASED;
            end
         end
      end
      for (int r = 0; r < FIELD_COUNT; r++) res.avail[r] = byte_type'(avail_units(r));
      return res;
   endfunction

   function automatic alloc_req_type random_request();
      alloc_req_type q;
      int         pick;
      int         c;
      int         r;
      pick = $urandom_range(99);
      c = $urandom_range(CFG_CUSTOMERS - 1);
      q.cmd = CMD_REQUEST;
      q.customer = CUST_W'(c);
      if (pick < 10) begin
         q.cmd = command_type'($urandom_range(1));
         q.customer = CUST_W'($urandom_range(7));
         for (int k = 0; k < FIELD_COUNT; k++) q.amount[k] = byte_type'($urandom_range(255));
      end else if (pick < 56) begin
         for (int k = 0; k < FIELD_COUNT; k++)
            q.amount[k] = byte_type'($urandom_range(need_units(c, k)));
         if (pick < 16) begin
            r = $urandom_range(FIELD_COUNT - 1);
            if (need_units(c, r) < 255) q.amount[r] = byte_type'(need_units(c, r) + 1);
         end
      end else begin
         q.cmd = CMD_RELEASE;
         for (int k = 0; k < FIELD_COUNT; k++)
            q.amount[k] = byte_type'($urandom_range(held[c][k]));
         if (pick < 61) begin
            r = $urandom_range(FIELD_COUNT - 1);
            if (held[c][r] < 255) q.amount[r] = byte_type'(held[c][r] + 1);
         end
      end
      return q;
   endfunction

   function automatic csr_word_type random_word(int lo, int hi);
      csr_word_type w;
      for (int r = 0; r < FIELD_COUNT; r++) w[8*r +: 8] = byte_type'($urandom_range(hi, lo));
      return w;
   endfunction

   function automatic void add_write(reg_index_type sel, csr_word_type v);
      script_row_type row;
      row.is_write = 1'b1;
      row.reg_sel = sel;
      row.wdata = v;
      row.item.cmd = CMD_REQUEST;
      row.item.customer = '0;
      row.item.amount = '0;
      row.typed = 1'b0;
      row.want_status = RSP_GRANTED;
      row.want_avail = '0;
      script.push_back(row);
   endfunction

   function automatic void add_item(command_type cmd, int cust, int a0, int a1, int a2, int a3,
                                    bit typed = 1'b0, status_type st = RSP_GRANTED,
                                    byte_type av = '0);
      script_row_type row;
      row.is_write = 1'b0;
      row.reg_sel = REG_TOTAL;
      row.wdata = '0;
      row.item.cmd = cmd;
      row.item.customer = CUST_W'(cust);
      row.item.amount = {byte_type'(a3), byte_type'(a2), byte_type'(a1), byte_type'(a0)};
      row.typed = typed;
      row.want_status = st;
      row.want_avail = av;
      script.push_back(row);
   endfunction

   task automatic write_csr(input reg_index_type sel, input csr_word_type v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= v;
      reg_words[sel] = v;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic issue(input alloc_req_type q, input bit typed, input status_type st,
                        input byte_type av);
      alloc_rsp_type want;
      @(negedge clock);
      start <= 1'b1;
      req_command <= q.cmd;
      req_customer <= q.customer;
      req_amount_0 <= q.amount[0];
      req_amount_1 <= q.amount[1];
      req_amount_2 <= q.amount[2];
      req_amount_3 <= q.amount[3];
      @(posedge clock);
      while (busy) @(posedge clock);
      want = allocate_outcome(q);
      if (typed) begin
         want.status = st;
         want.avail = {FIELD_COUNT{av}};
      end
      pending_outcomes.push_back(want);
      issued++;
   endtask

   always @(posedge clock) begin
      alloc_rsp_type              want;
      byte_type [FIELD_COUNT-1:0] got;
      if (!reset && rsp_valid) begin
         got = {rsp_avail_3, rsp_avail_2, rsp_avail_1, rsp_avail_0};
         received++;
         if (rsp_status < 6) outcome_count[rsp_status]++;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected response, status %0d avail %h", $time, rsp_status, got);
            failures++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               failures++;
            end
            for (int r = 0; r < FIELD_COUNT; r++) begin
               if (got[r] !== want.avail[r]) begin
                  $display("%0t: avail_%0d expected %0d got %0d", $time, r, want.avail[r],
                           got[r]);
                  failures++;
               end
            end
         end
      end
   end

   initial begin
      alloc_req_type  q;
      script_row_type row;
      int           gap_pct;
      csr_word_type cfg [REG_COUNT];

      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_REQUEST;
      req_customer = '0;
      req_amount_0 = '0;
      req_amount_1 = '0;
      req_amount_2 = '0;
      req_amount_3 = '0;
      csr_write_en = 1'b0;
      csr_index = REG_TOTAL;
      csr_wdata = '0;
      for (int i = 0; i < REG_COUNT; i++) reg_words[i] = '0;
      for (int r = 0; r < FIELD_COUNT; r++) begin
         held_total[r] = '0;
         for (int c = 0; c < CFG_CUSTOMERS; c++) held[c][r] = '0;
      end
      for (int s = 0; s < 6; s++) outcome_count[s] = 0;

      // registers all zero after reset
      add_item(CMD_REQUEST, 0, 0, 0, 0, 0, 1'b1, RSP_GRANTED, 8'd0);
      add_item(CMD_RELEASE, 0, 0, 0, 0, 0, 1'b1, RSP_RELEASED, 8'd0);
      add_item(CMD_REQUEST, 0, 1, 0, 0, 0, 1'b1, RSP_OVER_CLAIM, 8'd0);
      add_item(CMD_RELEASE, 0, 0, 0, 0, 1, 1'b1, RSP_REFUSED, 8'd0);
      add_item(CMD_REQUEST, 7, 0, 0, 0, 0, 1'b1, RSP_OVER_CLAIM, 8'd0);
      add_item(CMD_RELEASE, 5, 0, 0, 0, 0, 1'b1, RSP_REFUSED, 8'd0);
      // full pool
      add_write(REG_TOTAL, 32'hFFFF_FFFF);
      add_write(REG_CLAIM0, 32'hFFFF_FFFF);
      add_write(REG_CLAIM1, 32'h0101_0101);
      add_write(REG_CLAIM2, 32'h0101_0101);
      add_write(REG_CLAIM3, 32'h0101_0101);
      add_write(REG_CLAIM4, 32'h0101_0101);
      add_item(CMD_REQUEST, 0, 255, 255, 255, 255, 1'b1, RSP_GRANTED, 8'd0);
      add_item(CMD_REQUEST, 1, 1, 1, 1, 1, 1'b1, RSP_UNAVAILABLE, 8'd0);
      add_item(CMD_REQUEST, 4, 2, 0, 0, 0, 1'b1, RSP_OVER_CLAIM, 8'd0);
      add_item(CMD_RELEASE, 0, 255, 255, 255, 255, 1'b1, RSP_RELEASED, 8'd255);
      add_item(CMD_RELEASE, 0, 1, 0, 0, 0, 1'b1, RSP_REFUSED, 8'd255);
      add_item(CMD_REQUEST, 4, 1, 1, 1, 1);
      add_item(CMD_RELEASE, 4, 1, 1, 1, 1);
      // two customers contending for two units each
      add_write(REG_TOTAL, 32'h0202_0202);
      add_write(REG_CLAIM0, 32'h0202_0202);
      add_write(REG_CLAIM1, 32'h0202_0202);
      add_write(REG_CLAIM2, 32'h0);
      add_write(REG_CLAIM3, 32'h0);
      add_write(REG_CLAIM4, 32'h0);
      add_item(CMD_REQUEST, 0, 1, 1, 1, 1);
      add_item(CMD_REQUEST, 1, 1, 1, 1, 1);
      add_item(CMD_REQUEST, 1, 1, 0, 0, 0);
      // registers lowered below holdings
      add_write(REG_TOTAL, 32'h0);
      add_item(CMD_REQUEST, 2, 0, 0, 0, 0);
      add_write(REG_CLAIM0, 32'h0);
      add_item(CMD_RELEASE, 0, 1, 1, 1, 1);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         row = script[i];
         if (row.is_write) begin
            drain();
            write_csr(row.reg_sel, row.wdata);
         end else begin
            issue(row.item, row.typed, row.want_status, row.want_avail);
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         drain();
         case (phase)
            1: begin
               foreach (cfg[i]) cfg[i] = 32'hFFFF_FFFF;
            end
            2: begin
               cfg[REG_TOTAL] = random_word(0, 3);
               for (int i = 1; i < REG_COUNT; i++) cfg[i] = random_word(0, 4);
            end
            3: begin
               foreach (cfg[i]) cfg[i] = '0;
            end
            4: begin
               foreach (cfg[i]) cfg[i] = $urandom;
            end
            6: begin
               cfg[REG_TOTAL] = 32'hFFFF_FFFF;
               for (int i = 1; i < REG_COUNT; i++) cfg[i] = random_word(0, 255);
            end
            default: begin
               cfg[REG_TOTAL] = random_word(3, 10);
               for (int i = 1; i < REG_COUNT; i++) cfg[i] = random_word(0, 8);
            end
         endcase
         foreach (cfg[i]) write_csr(reg_index_type'(i), cfg[i]);
         settings++;
         gap_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 57 : 27;
         repeat (106) begin
            if ($urandom_range(99) < gap_pct) pause_sender($urandom_range(40, 1));
            q = random_request();
            issue(q, 1'b0, RSP_GRANTED, '0);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d transactions, %0d responses over %0d random register settings",
               issued, received, settings);
      $display("granted %0d unsafe %0d unavailable %0d over claim %0d released %0d refused %0d",
               outcome_count[0], outcome_count[1], outcome_count[2], outcome_count[3],
               outcome_count[4], outcome_count[5]);
      if (failures == 0 && pending_outcomes.size() == 0) begin
         $display("bankers_safety_allocator verification clean");
      end else begin
         $display("bankers_safety_allocator verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/bsa_pkg.sv
sv/bsa_regfile.sv
sv/bsa_vec_unit.sv
sv/bankers_safety_allocator.sv
verif/testbench.sv
